@@ rtl/rlse_pkg.sv @@
// Package for the RGB LED effect sequencer: level and step types, phase and
// mode codes, the demo colour table and the small helpers for fade arithmetic.
// No dependencies.
package rlse_pkg;

  localparam int unsigned LVL_W  = 10;
  localparam int unsigned STP_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TPS_W  = 16;
  localparam int unsigned CHANS  = 3;

  localparam logic [LVL_W-1:0]  LVL_MAX   = {LVL_W{1'b1}};
  localparam logic [TPS_W-1:0]  TPS_RESET = 16'd100;
  localparam logic [2:0]        DEMO_COLORS = 3'd6;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [BYTE_W-1:0] MODE_GLOW  = 8'd0;
  localparam logic [BYTE_W-1:0] MODE_BLINK = 8'd1;
  localparam logic [BYTE_W-1:0] MODE_FADE  = 8'd2;
  localparam logic [BYTE_W-1:0] MODE_DEMO  = 8'd255;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_GLOW,
    PH_BLINK_ON,
    PH_BLINK_OFF,
    PH_FADE_UP,
    PH_FADE_DOWN
  } phase_e;

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [STP_W-1:0]  stp_t;
  typedef lvl_t [CHANS-1:0]  lvl_vec_t;
  typedef stp_t [CHANS-1:0]  stp_vec_t;
  typedef logic [CHANS-1:0][BYTE_W-1:0] rgb_t;

  typedef struct packed {
    lvl_t up;
    lvl_t dn;
  } ramp_t;

  typedef struct packed {
    phase_e      phase;
    lvl_vec_t    lvl;
    lvl_vec_t    tgt;
    stp_vec_t    stp;
    logic [7:0]  rep;
    logic [2:0]  idx;
    logic [7:0]  passes;
  } fx_t;

  function automatic lvl_t byte_to_level(logic [BYTE_W-1:0] b);
    return {b, 2'b00};
  endfunction

  // Level divided by 192 for levels up to 1020: (level / 64) * 11 / 32.
  function automatic stp_t fade_step(lvl_t l);
    logic [7:0] p;
    p = 8'(l[LVL_W-1:6]) * 8'd11;
    return p[7:5];
  endfunction

  function automatic rgb_t demo_rgb(logic [2:0] idx);
    rgb_t c;
    case (idx)
      3'd1:    begin c[0] = 8'hff; c[1] = 8'hff; c[2] = 8'h00; end
      3'd2:    begin c[0] = 8'h00; c[1] = 8'hff; c[2] = 8'h00; end
      3'd3:    begin c[0] = 8'h00; c[1] = 8'hff; c[2] = 8'hff; end
      3'd4:    begin c[0] = 8'h00; c[1] = 8'h00; c[2] = 8'hff; end
      3'd5:    begin c[0] = 8'hff; c[1] = 8'h00; c[2] = 8'hff; end
      default: begin c[0] = 8'hff; c[1] = 8'h00; c[2] = 8'h00; end
    endcase
    return c;
  endfunction

  function automatic logic any_up(lvl_vec_t lvl, lvl_vec_t tgt, stp_vec_t stp);
    logic r;
    r = 1'b0;
    for (int c = 0; c < CHANS; c++) begin
      if (stp[c] != '0 && lvl[c] < tgt[c]) r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic any_dn(lvl_vec_t lvl, stp_vec_t stp);
    logic r;
    r = 1'b0;
    for (int c = 0; c < CHANS; c++) begin
      if (stp[c] != '0 && lvl[c] > lvl_t'(stp[c])) r = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/rlse_chan.sv @@
// One colour channel of the fade ramp: the next level for a step up, with
// saturation, and for a step down. Depends on rlse_pkg.
module rlse_chan import rlse_pkg::*; (
  input  lvl_t  tgt_i,
  input  stp_t  stp_i,
  input  lvl_t  lvl_i,
  output ramp_t ramp_o
);

  logic [LVL_W:0] sum;

  assign sum = {1'b0, lvl_i} + (LVL_W+1)'(stp_i);

  always_comb begin
    ramp_o.up = lvl_i;
    if (stp_i != '0 && lvl_i < tgt_i) begin
      ramp_o.up = sum[LVL_W] ? LVL_MAX : sum[LVL_W-1:0];
    end
    ramp_o.dn = (lvl_i >= lvl_t'(stp_i)) ? lvl_i - lvl_t'(stp_i) : lvl_i;
  end

endmodule

@@ rtl/rgb_led_effect_sequencer_core.sv @@
// Top level of the RGB LED effect sequencer: input register, effect state,
// result register. Depends on rlse_pkg and rlse_chan.
//
// Usage: the input channel carries one beat per command or per 10 ms tick,
// selected by kind_i. A command starts glow, blink, fade or demo with the given
// colour and count; a command that arrives while an effect runs is dropped and
// flagged by rejected_o. Every input beat yields exactly one output beat with
// the current red, green and blue levels and the busy flag.
// The user must write the tick rate per second through cfg_we_i / cfg_wdata_i
// only while the block is idle; the block itself does not enforce this. A value
// of zero acts as one. An accepted beat is held in the input register, and its
// result is then held in the result register. Throughput is one beat per cycle
// while the receiver keeps out_ready_i high, set by the single pass of compare
// and add logic per channel.
// Reset clears the effect state to idle with all levels zero and sets the
// tick rate to 100. When the receiver stalls, the result register holds its
// beat and the input register still takes one more beat; after that
// in_ready_o falls until out_ready_i returns.
module rgb_led_effect_sequencer_core import rlse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TPS_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [BYTE_W-1:0] red_in_i,
  input  logic [BYTE_W-1:0] green_in_i,
  input  logic [BYTE_W-1:0] blue_in_i,
  input  logic [BYTE_W-1:0] mode_in_i,
  input  logic [BYTE_W-1:0] count_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LVL_W-1:0]  red_level_o,
  output logic [LVL_W-1:0]  green_level_o,
  output logic [LVL_W-1:0]  blue_level_o,
  output logic              busy_res_o,
  output logic              rejected_o
);

  logic              s1_valid_q;
  logic              kind_q;
  rgb_t              rgb_q;
  logic [BYTE_W-1:0] mode_q;
  logic [BYTE_W-1:0] count_q;

  logic [TPS_W-1:0]  tps_q;
  lvl_vec_t          tgt_q, tgt_d;
  stp_vec_t          stp_q, stp_d;
  lvl_vec_t          lvl_q, lvl_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        rep_q, rep_d;
  logic [2:0]        idx_q, idx_d;
  logic [7:0]        passes_q, passes_d;
  logic [TPS_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q;
  lvl_vec_t          res_lvl_q;
  logic              res_busy_q;
  logic              res_rej_q;

  logic              adv;
  logic              step_en;
  logic              rej;
  logic [TPS_W-1:0]  reload;
  ramp_t [CHANS-1:0] ramp;

  function automatic fx_t fx_settle(fx_t s);
    fx_t        r;
    logic [7:0] rep_n;
    logic [2:0] idx_n;
    logic [7:0] pass_n;
    rgb_t       c;
    r = s;
    if (r.phase == PH_FADE_UP && !any_up(r.lvl, r.tgt, r.stp)) begin
      r.phase = PH_FADE_DOWN;
    end
    if (r.phase == PH_FADE_DOWN && !any_dn(r.lvl, r.stp)) begin
      rep_n = (r.rep != '0) ? r.rep - 8'd1 : '0;
      // With every step zero the ramps finish at once, so all repeats go.
      if (r.stp == '0) rep_n = '0;
      r.rep = rep_n;
      if (rep_n != '0) begin
        r.phase = PH_FADE_UP;
      end else begin
        r.lvl = '0;
        if (r.passes == '0) begin
          r.phase = PH_IDLE;
        end else begin
          idx_n  = r.idx + 3'd1;
          pass_n = r.passes;
          if (idx_n >= DEMO_COLORS) begin
            idx_n  = '0;
            pass_n = pass_n - 8'd1;
          end
          r.idx    = idx_n;
          r.passes = pass_n;
          if (pass_n == '0) begin
            r.phase = PH_IDLE;
          end else begin
            c = demo_rgb(idx_n);
            for (int k = 0; k < CHANS; k++) begin
              r.tgt[k] = byte_to_level(c[k]);
              r.stp[k] = fade_step(r.tgt[k]);
            end
            r.rep   = 8'd1;
            r.phase = PH_FADE_UP;
          end
        end
      end
    end
    return r;
  endfunction

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;
  assign step_en    = s1_valid_q && adv;
  assign reload     = (tps_q == '0) ? TPS_W'(1) : tps_q;

  for (genvar g = 0; g < CHANS; g++) begin : g_chan
    rlse_chan u_chan (
      .tgt_i  (tgt_q[g]),
      .stp_i  (stp_q[g]),
      .lvl_i  (lvl_q[g]),
      .ramp_o (ramp[g])
    );
  end

  always_comb begin
    fx_t              fx;
    lvl_vec_t         new_tgt;
    logic [TPS_W-1:0] cnt_dec;
    logic [7:0]       rep_dec;
    rgb_t             c;

    tgt_d    = tgt_q;
    stp_d    = stp_q;
    lvl_d    = lvl_q;
    phase_d  = phase_q;
    rep_d    = rep_q;
    idx_d    = idx_q;
    passes_d = passes_q;
    cnt_d    = cnt_q;
    rej      = 1'b0;

    fx.phase  = phase_q;
    fx.lvl    = lvl_q;
    fx.tgt    = tgt_q;
    fx.stp    = stp_q;
    fx.rep    = rep_q;
    fx.idx    = idx_q;
    fx.passes = passes_q;

    cnt_dec = (cnt_q != '0) ? cnt_q - TPS_W'(1) : '0;
    rep_dec = (rep_q != '0) ? rep_q - 8'd1 : '0;
    for (int k = 0; k < CHANS; k++) begin
      new_tgt[k] = byte_to_level(rgb_q[k]);
    end
    c = demo_rgb(3'd0);

    if (kind_q == KIND_TICK) begin
      case (phase_q)
        PH_GLOW, PH_BLINK_ON, PH_BLINK_OFF: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            cnt_d = reload;
            if (phase_q == PH_BLINK_ON) begin
              lvl_d   = '0;
              phase_d = PH_BLINK_OFF;
            end else begin
              rep_d = rep_dec;
              if (rep_dec == '0) begin
                lvl_d   = '0;
                phase_d = PH_IDLE;
                cnt_d   = '0;
              end else if (phase_q == PH_BLINK_OFF) begin
                lvl_d   = tgt_q;
                phase_d = PH_BLINK_ON;
              end
            end
          end
        end
        PH_FADE_UP, PH_FADE_DOWN: begin
          for (int k = 0; k < CHANS; k++) begin
            fx.lvl[k] = (phase_q == PH_FADE_UP) ? ramp[k].up : ramp[k].dn;
          end
          fx       = fx_settle(fx);
          phase_d  = fx.phase;
          lvl_d    = fx.lvl;
          tgt_d    = fx.tgt;
          stp_d    = fx.stp;
          rep_d    = fx.rep;
          idx_d    = fx.idx;
          passes_d = fx.passes;
        end
        default: begin
        end
      endcase
    end else if (phase_q != PH_IDLE) begin
      rej = 1'b1;
    end else begin
      tgt_d    = new_tgt;
      passes_d = '0;
      case (mode_q)
        MODE_GLOW: begin
          if (count_q == '0) begin
            lvl_d = '0;
          end else begin
            lvl_d   = new_tgt;
            rep_d   = count_q;
            cnt_d   = reload;
            phase_d = PH_GLOW;
          end
        end
        MODE_BLINK: begin
          if (count_q != '0) begin
            lvl_d   = new_tgt;
            rep_d   = count_q;
            cnt_d   = reload;
            phase_d = PH_BLINK_ON;
          end
        end
        MODE_FADE: begin
          for (int k = 0; k < CHANS; k++) begin
            stp_d[k] = fade_step(new_tgt[k]);
          end
          if (count_q == '0) begin
            lvl_d = '0;
          end else begin
            fx.tgt    = new_tgt;
            fx.stp    = stp_d;
            fx.rep    = count_q;
            fx.passes = '0;
            fx.phase  = PH_FADE_UP;
            fx        = fx_settle(fx);
            phase_d   = fx.phase;
            lvl_d     = fx.lvl;
            tgt_d     = fx.tgt;
            stp_d     = fx.stp;
            rep_d     = fx.rep;
            idx_d     = fx.idx;
            passes_d  = fx.passes;
          end
        end
        MODE_DEMO: begin
          if (count_q != '0) begin
            for (int k = 0; k < CHANS; k++) begin
              fx.tgt[k] = byte_to_level(c[k]);
              fx.stp[k] = fade_step(fx.tgt[k]);
            end
            fx.rep    = 8'd1;
            fx.idx    = '0;
            fx.passes = count_q;
            fx.phase  = PH_FADE_UP;
            fx        = fx_settle(fx);
            phase_d   = fx.phase;
            lvl_d     = fx.lvl;
            tgt_d     = fx.tgt;
            stp_d     = fx.stp;
            rep_d     = fx.rep;
            idx_d     = fx.idx;
            passes_d  = fx.passes;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tps_q       <= TPS_RESET;
      tgt_q       <= '0;
      stp_q       <= '0;
      lvl_q       <= '0;
      phase_q     <= PH_IDLE;
      rep_q       <= '0;
      idx_q       <= '0;
      passes_q    <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (step_en) begin
        tgt_q    <= tgt_d;
        stp_q    <= stp_d;
        lvl_q    <= lvl_d;
        phase_q  <= phase_d;
        rep_q    <= rep_d;
        idx_q    <= idx_d;
        passes_q <= passes_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q   <= kind_i;
      rgb_q[0] <= red_in_i;
      rgb_q[1] <= green_in_i;
      rgb_q[2] <= blue_in_i;
      mode_q   <= mode_in_i;
      count_q  <= count_in_i;
    end
    if (step_en) begin
      res_lvl_q  <= lvl_d;
      res_busy_q <= (phase_d != PH_IDLE);
      res_rej_q  <= rej;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_level_o   = res_lvl_q[0];
  assign green_level_o = res_lvl_q[1];
  assign blue_level_o  = res_lvl_q[2];
  assign busy_res_o    = res_busy_q;
  assign rejected_o    = res_rej_q;

  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o)
    else $error("rejected beat reported while not busy");

  a_idle_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> lvl_q == '0)
    else $error("levels not zero while idle");

  a_fade_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FADE_UP || phase_q == PH_FADE_DOWN) |-> stp_q != '0)
    else $error("fade running with all steps zero");

  a_timer_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GLOW || phase_q == PH_BLINK_ON || phase_q == PH_BLINK_OFF)
      |-> cnt_q != '0)
    else $error("tick countdown empty during glow or blink");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(lvl_q) && $stable(phase_q))
    else $error("effect state advanced while the result was stalled");

endmodule

@@ verif/rgb_led_effect_sequencer_core_test.sv @@
// Self-checking testbench for rgb_led_effect_sequencer_core: drives command and tick beats,
// predicts the level beat of every accepted input and compares it with the block's output.
// Depends on rlse_pkg and the RTL of the sequencer.
`timescale 1ns / 100ps

module rgb_led_effect_sequencer_core_test;
  import rlse_pkg::*;

  localparam int unsigned FADE_DIVISOR = 192;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] mode;
    logic [BYTE_W-1:0] count;
  } led_req_t;

  typedef struct packed {
    lvl_t red;
    lvl_t green;
    lvl_t blue;
    logic busy;
    logic rejected;
  } led_levels_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [TPS_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              kind_i      = KIND_CMD;
  logic [BYTE_W-1:0] red_in_i    = '0;
  logic [BYTE_W-1:0] green_in_i  = '0;
  logic [BYTE_W-1:0] blue_in_i   = '0;
  logic [BYTE_W-1:0] mode_in_i   = '0;
  logic [BYTE_W-1:0] count_in_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [LVL_W-1:0]  red_level_o;
  logic [LVL_W-1:0]  green_level_o;
  logic [LVL_W-1:0]  blue_level_o;
  logic              busy_res_o;
  logic              rejected_o;

  rgb_led_effect_sequencer_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .mode_in_i    (mode_in_i),
    .count_in_i   (count_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_level_o  (red_level_o),
    .green_level_o(green_level_o),
    .blue_level_o (blue_level_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Effect state of the predictor.
  phase_e           fx_phase;
  lvl_t             fx_tgt[CHANS];
  lvl_t             fx_lvl[CHANS];
  stp_t             fx_stp[CHANS];
  logic [7:0]       fx_rep;
  logic [7:0]       fx_passes;
  logic [2:0]       fx_idx;
  logic [TPS_W-1:0] fx_cnt;
  logic [TPS_W-1:0] tick_rate;

  led_req_t    beats_to_send[$];
  led_levels_t levels_due_q[$];
  led_req_t    cur_req;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  logic [31:0] ready_pattern = '0;
  int unsigned pattern_left  = 0;
  int unsigned mismatches    = 0;

  function automatic void clear_model();
    fx_phase  = PH_IDLE;
    for (int c = 0; c < CHANS; c++) begin
      fx_tgt[c] = '0;
      fx_lvl[c] = '0;
      fx_stp[c] = '0;
    end
    fx_rep    = '0;
    fx_passes = '0;
    fx_idx    = '0;
    fx_cnt    = '0;
    tick_rate = TPS_RESET;
  endfunction

  function automatic logic [TPS_W-1:0] rate_reload();
    return (tick_rate == '0) ? TPS_W'(1) : tick_rate;
  endfunction

  function automatic lvl_t scaled(logic [7:0] v);
    int unsigned s;
    s = v * 4;
    return (s > LVL_MAX) ? LVL_MAX : lvl_t'(s);
  endfunction

  function automatic void set_targets(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    fx_tgt[0] = scaled(r);
    fx_tgt[1] = scaled(g);
    fx_tgt[2] = scaled(b);
  endfunction

  function automatic void derive_steps();
    for (int c = 0; c < CHANS; c++) fx_stp[c] = stp_t'(fx_tgt[c] / FADE_DIVISOR);
  endfunction

  function automatic void all_lit();
    for (int c = 0; c < CHANS; c++) fx_lvl[c] = fx_tgt[c];
  endfunction

  function automatic void all_dark();
    for (int c = 0; c < CHANS; c++) fx_lvl[c] = '0;
  endfunction

  function automatic logic rising_left();
    logic r;
    r = 1'b0;
    for (int c = 0; c < CHANS; c++) begin
      if (fx_stp[c] != '0 && fx_lvl[c] < fx_tgt[c]) r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic falling_left();
    logic r;
    r = 1'b0;
    for (int c = 0; c < CHANS; c++) begin
      if (fx_stp[c] != '0 && fx_lvl[c] > lvl_t'(fx_stp[c])) r = 1'b1;
    end
    return r;
  endfunction

  // Demo colours: red, yellow, green, cyan, blue, magenta.
  function automatic void load_demo_shade();
    logic [7:0] r, g, b;
    r = (fx_idx == 3'd0 || fx_idx == 3'd1 || fx_idx == 3'd5) ? 8'hff : 8'h00;
    g = (fx_idx == 3'd1 || fx_idx == 3'd2 || fx_idx == 3'd3) ? 8'hff : 8'h00;
    b = (fx_idx == 3'd3 || fx_idx == 3'd4 || fx_idx == 3'd5) ? 8'hff : 8'h00;
    if (fx_idx >= DEMO_COLORS) begin
      r = 8'hff;
      g = 8'h00;
      b = 8'h00;
    end
    set_targets(r, g, b);
    derive_steps();
    fx_rep = 8'd1;
  endfunction

  // Moves through every ramp whose work is already complete.
  function automatic void finish_ramps();
    logic done;
    done = 1'b0;
    while (!done) begin
      if (fx_phase == PH_FADE_UP) begin
        if (rising_left()) done = 1'b1;
        else fx_phase = PH_FADE_DOWN;
      end
      if (!done) begin
        if (fx_phase != PH_FADE_DOWN || falling_left()) begin
          done = 1'b1;
        end else begin
          if (fx_rep != '0) fx_rep--;
          if (fx_rep != '0) begin
            fx_phase = PH_FADE_UP;
          end else begin
            all_dark();
            if (fx_passes != '0) begin
              fx_idx++;
              if (fx_idx >= DEMO_COLORS) begin
                fx_idx = '0;
                fx_passes--;
              end
            end
            if (fx_passes == '0) begin
              fx_phase = PH_IDLE;
              done = 1'b1;
            end else begin
              load_demo_shade();
              fx_phase = PH_FADE_UP;
            end
          end
        end
      end
    end
  endfunction

  function automatic void advance_tick();
    logic [LVL_W:0] sum;
    case (fx_phase)
      PH_GLOW, PH_BLINK_ON, PH_BLINK_OFF: begin
        if (fx_cnt != '0) fx_cnt--;
        if (fx_cnt == '0) begin
          fx_cnt = rate_reload();
          if (fx_phase == PH_BLINK_ON) begin
            all_dark();
            fx_phase = PH_BLINK_OFF;
          end else begin
            if (fx_rep != '0) fx_rep--;
            if (fx_rep == '0) begin
              all_dark();
              fx_phase = PH_IDLE;
              fx_cnt = '0;
            end else if (fx_phase == PH_BLINK_OFF) begin
              all_lit();
              fx_phase = PH_BLINK_ON;
            end
          end
        end
      end
      PH_FADE_UP: begin
        for (int c = 0; c < CHANS; c++) begin
          if (fx_stp[c] != '0 && fx_lvl[c] < fx_tgt[c]) begin
            sum = {1'b0, fx_lvl[c]} + (LVL_W+1)'(fx_stp[c]);
            fx_lvl[c] = (sum > {1'b0, LVL_MAX}) ? LVL_MAX : sum[LVL_W-1:0];
          end
        end
        finish_ramps();
      end
      PH_FADE_DOWN: begin
        for (int c = 0; c < CHANS; c++) begin
          if (fx_lvl[c] >= lvl_t'(fx_stp[c])) fx_lvl[c] = fx_lvl[c] - lvl_t'(fx_stp[c]);
        end
        finish_ramps();
      end
      default: ;
    endcase
  endfunction

  function automatic void start_effect(led_req_t q);
    set_targets(q.red, q.green, q.blue);
    fx_passes = '0;
    case (q.mode)
      MODE_GLOW: begin
        all_lit();
        if (q.count == '0) begin
          all_dark();
        end else begin
          fx_rep   = q.count;
          fx_cnt   = rate_reload();
          fx_phase = PH_GLOW;
        end
      end
      MODE_BLINK: begin
        if (q.count != '0) begin
          all_lit();
          fx_rep   = q.count;
          fx_cnt   = rate_reload();
          fx_phase = PH_BLINK_ON;
        end
      end
      MODE_FADE: begin
        derive_steps();
        if (q.count == '0) begin
          all_dark();
        end else begin
          fx_rep   = q.count;
          fx_phase = PH_FADE_UP;
          finish_ramps();
        end
      end
      MODE_DEMO: begin
        if (q.count != '0) begin
          fx_passes = q.count;
          fx_idx    = '0;
          load_demo_shade();
          fx_phase  = PH_FADE_UP;
          finish_ramps();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic led_levels_t predict_levels(led_req_t q);
    led_levels_t res;
    res.rejected = 1'b0;
    if (q.kind == KIND_TICK) advance_tick();
    else if (fx_phase != PH_IDLE) res.rejected = 1'b1;
    else start_effect(q);
    res.red   = fx_lvl[0];
    res.green = fx_lvl[1];
    res.blue  = fx_lvl[2];
    res.busy  = (fx_phase != PH_IDLE);
    return res;
  endfunction

  function automatic void push_command(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic [7:0] mode, logic [7:0] count);
    led_req_t q;
    q.kind  = KIND_CMD;
    q.red   = r;
    q.green = g;
    q.blue  = b;
    q.mode  = mode;
    q.count = count;
    beats_to_send.push_back(q);
  endfunction

  // Ticks carry random colour, mode and count bytes, which the block must ignore.
  function automatic void push_ticks(int unsigned n);
    led_req_t q;
    repeat (n) begin
      q.kind  = KIND_TICK;
      q.red   = 8'($urandom);
      q.green = 8'($urandom);
      q.blue  = 8'($urandom);
      q.mode  = 8'($urandom);
      q.count = 8'($urandom);
      beats_to_send.push_back(q);
    end
  endfunction

  function automatic logic [7:0] random_shade();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(0, 47));
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_random_command();
    int unsigned pick;
    logic [7:0]  mode, count;
    pick = $urandom_range(0, 99);
    if (pick < 28) mode = MODE_GLOW;
    else if (pick < 56) mode = MODE_BLINK;
    else if (pick < 78) mode = MODE_FADE;
    else if (pick < 81) mode = MODE_DEMO;
    else mode = 8'($urandom_range(3, 254));
    if (mode == MODE_DEMO) begin
      count = '0;
    end else if (mode == MODE_FADE) begin
      count = 8'($urandom_range(0, 2));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8) count = '0;
      else if (pick < 85) count = 8'($urandom_range(1, 4));
      else count = 8'($urandom_range(5, 30));
    end
    push_command(random_shade(), random_shade(), random_shade(), mode, count);
  endfunction

  task automatic wait_drained();
    @(negedge clk_i);
    while (beats_to_send.size() != 0 || in_valid_i || levels_due_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Feeds ticks until the running effect has ended and every beat has been checked.
  task automatic run_out_effect();
    wait_drained();
    while (fx_phase != PH_IDLE) begin
      push_ticks(32);
      wait_drained();
    end
  endtask

  task automatic write_rate(logic [TPS_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tick_rate = v;
  endtask

  // Sender: bursts of random length separated by random gaps, now and then a long burst.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) levels_due_q.push_back(predict_levels(cur_req));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          cur_req = beats_to_send.pop_front();
          in_valid_i <= 1'b1;
          kind_i     <= cur_req.kind;
          red_in_i   <= cur_req.red;
          green_in_i <= cur_req.green;
          blue_in_i  <= cur_req.blue;
          mode_in_i  <= cur_req.mode;
          count_in_i <= cur_req.count;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a bit pattern that is renewed once all 32 of its bits are used.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      pattern_left = 0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = '1;
          1:       ready_pattern = $urandom;
          default: ready_pattern = $urandom | $urandom;
        endcase
        pattern_left = 32;
      end
      out_ready_i <= ready_pattern[0];
      ready_pattern = ready_pattern >> 1;
      pattern_left--;
    end
  end

  always @(posedge clk_i) begin
    led_levels_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{red_level_o, green_level_o, blue_level_o, busy_res_o, rejected_o};
      if (levels_due_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: output beat with nothing expected: r=%0d g=%0d b=%0d busy=%0b rej=%0b",
                   $time, got.red, got.green, got.blue, got.busy, got.rejected);
        mismatches++;
      end else begin
        want = levels_due_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("%0t: expected r=%0d g=%0d b=%0d busy=%0b rej=%0b, got r=%0d g=%0d b=%0d busy=%0b rej=%0b",
                     $time, want.red, want.green, want.blue, want.busy, want.rejected,
                     got.red, got.green, got.blue, got.busy, got.rejected);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [TPS_W-1:0] rates[4];
    clear_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_ticks(1);
    push_command(8'hff, 8'h00, 8'h80, 8'd3, 8'd5);
    push_command(8'hff, 8'hff, 8'hff, MODE_GLOW, 8'd0);
    push_command(8'h12, 8'h34, 8'h56, MODE_BLINK, 8'd0);
    push_command(8'd200, 8'd10, 8'hff, MODE_FADE, 8'd0);
    push_command(8'h00, 8'h00, 8'h00, MODE_DEMO, 8'd0);
    push_command(8'd47, 8'd47, 8'd0, MODE_FADE, 8'd3);
    push_command(8'hff, 8'h00, 8'h00, MODE_GLOW, 8'd1);
    push_ticks(3);
    push_command(8'h01, 8'h02, 8'h03, MODE_BLINK, 8'd2);
    run_out_effect();

    write_rate(TPS_W'(1));
    push_command(8'h80, 8'h7f, 8'h01, MODE_GLOW, 8'd40);
    push_ticks(2);
    push_command(8'hff, 8'hff, 8'hff, MODE_FADE, 8'd1);
    run_out_effect();
    push_command(8'hff, 8'hff, 8'hff, MODE_BLINK, 8'd3);
    run_out_effect();
    push_command(8'hff, 8'd100, 8'd30, MODE_FADE, 8'd2);
    run_out_effect();
    push_command(8'h00, 8'h00, 8'h00, MODE_DEMO, 8'd1);
    push_ticks(5);
    push_command(8'hff, 8'hff, 8'hff, MODE_DEMO, 8'hff);
    run_out_effect();

    rates[0] = '0;
    rates[1] = TPS_W'(2);
    rates[2] = TPS_W'($urandom_range(3, 12));
    rates[3] = TPS_W'(1);
    foreach (rates[p]) begin
      write_rate(rates[p]);
      repeat (100) begin
        if ($urandom_range(0, 99) < 18) push_random_command();
        else push_ticks(1);
      end
      run_out_effect();
    end

    write_rate('1);
    push_command(8'hff, 8'h80, 8'h40, MODE_GLOW, 8'd1);
    push_ticks(10);
    push_command(8'h10, 8'h20, 8'h30, MODE_BLINK, 8'd1);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && levels_due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
